// ===== rtl/servo_drive_can_reply_decoder_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef SERVO_DRIVE_CAN_REPLY_DECODER_MACROS_SVH
`define SERVO_DRIVE_CAN_REPLY_DECODER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define SVCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define SVCD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/svcd_pkg.sv =====
// Types and constants of the servo drive CAN reply decoder.
package svcd_pkg;

  localparam int unsigned ID_W      = 11;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned DIN_W     = 21;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned NUM_SLOTS = 9;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned NUM_FAILS = 6;

  // configuration register indexes
  localparam logic CFG_SAMPLE_ID = 1'b0;
  localparam logic CFG_REPLY_ID  = 1'b1;

  // command letters, byte 1 in the upper half
  localparam logic [15:0] CMD_SR = 16'h5253;
  localparam logic [15:0] CMD_MF = 16'h464D;
  localparam logic [15:0] CMD_HM = 16'h4D48;
  localparam logic [15:0] CMD_IQ = 16'h5149;
  localparam logic [15:0] CMD_IP = 16'h5049;

  // status word classification
  localparam logic [31:0] SR_CLASS_MASK  = 32'h0000000E;
  localparam logic [31:0] SR_CLASS_HEAT  = 32'd12;
  localparam logic [31:0] SR_CLASS_SHORT = 32'd10;
  localparam logic [31:0] SR_CLASS_OVERV = 32'd4;
  localparam logic [31:0] SR_CLASS_UNDRV = 32'd2;
  localparam logic [31:0] DIN_MASK       = 32'h001FFFFF;

  // failure bits of a motor-failure reply, in report order
  localparam int unsigned FAIL_BITS [NUM_FAILS] = '{2, 3, 7, 8, 17, 21};

  // event codes
  localparam logic [CODE_W-1:0] EV_OK            = 4'd0;
  localparam logic [CODE_W-1:0] EV_OVERHEAT      = 4'd1;
  localparam logic [CODE_W-1:0] EV_SHORT         = 4'd2;
  localparam logic [CODE_W-1:0] EV_OVERVOLT      = 4'd3;
  localparam logic [CODE_W-1:0] EV_UNDERVOLT     = 4'd4;
  localparam logic [CODE_W-1:0] EV_MOTOR_OFF     = 4'd5;
  localparam logic [CODE_W-1:0] EV_FEEDBACK_LOSS = 4'd6;
  localparam logic [CODE_W-1:0] EV_DISARMED      = 4'd12;

  // result slots of one frame, emitted lowest first
  localparam logic [SLOT_W-1:0] SLOT_STATUS = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_HOMING = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_SAMPLE = 4'd8;

  typedef struct packed {
    logic [31:0]      position;
    logic [31:0]      velocity;
    logic [DIN_W-1:0] din;
    logic [31:0]      status;
    logic [31:0]      current;
  } latch_t;

  typedef struct packed {
    latch_t                snap;
    logic [CODE_W-1:0]     sr_code;
    logic                  sr_ask;
    logic [NUM_SLOTS-1:0]  pend;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [CODE_W-1:0] slot_code(input logic [SLOT_W-1:0] sel,
                                                  input logic [CODE_W-1:0] sr_code);
    logic [CODE_W-1:0] code;
    case (sel)
      SLOT_STATUS: code = sr_code;
      SLOT_HOMING: code = EV_DISARMED;
      SLOT_SAMPLE: code = EV_OK;
      default:     code = CODE_W'(EV_FEEDBACK_LOSS + sel - 4'd1);
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/servo_drive_can_reply_decoder.sv =====
// Top level of the servo drive CAN reply decoder.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  input    | in_push/in_full  | in_frame_id, in_payload
//  result   | out_pop/out_empty| out_event_code ... out_current_bits
//  config   | cfg_wr_en        | cfg_index, cfg_wdata
//
// A frame is taken in any cycle the queue has room; frames that cause no
// result only update the latched values. The back end emits one result
// word per cycle while the result side takes them; a frame has 1..7 results.
// A frame reaches the output register via the queue and the current entry.
// rst_n is synchronous; it clears the ID registers, latched values, queue
// and output stage. A stalled result side backs up the queue, then in_full.
module servo_drive_can_reply_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [svcd_pkg::ID_W-1:0]       cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [svcd_pkg::ID_W-1:0]       in_frame_id,
  input  logic [svcd_pkg::PAYLOAD_W-1:0]  in_payload,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [svcd_pkg::CODE_W-1:0]     out_event_code,
  output logic                            out_ask_failure_detail,
  output logic                            out_last,
  output logic signed [31:0]              out_position_count,
  output logic signed [31:0]              out_velocity_count,
  output logic [svcd_pkg::DIN_W-1:0]      out_digital_inputs,
  output logic [31:0]                     out_status_word,
  output logic [31:0]                     out_current_bits
);
  import svcd_pkg::*;

  // front -> queue
  logic                 q_full, q_push;
  entry_t               q_wentry;
  // queue -> back
  logic                 q_empty, q_pop;
  logic [ENTRY_W-1:0]   q_rdata;
  entry_t               q_rentry;

  assign q_rentry = q_rdata;

  // matching, classification and the latched drive values
  svcd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_push     (in_push),
    .in_frame_id (in_frame_id),
    .in_payload  (in_payload),
    .q_full      (q_full),
    .in_full     (in_full),
    .q_push      (q_push),
    .q_entry     (q_wentry)
  );

  // each entry carries its own snapshot of the latched values
  svcd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wentry),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // result expansion and output register
  svcd_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .q_entry                (q_rentry),
    .q_pop                  (q_pop),
    .out_pop                (out_pop),
    .out_empty              (out_empty),
    .out_event_code         (out_event_code),
    .out_ask_failure_detail (out_ask_failure_detail),
    .out_last               (out_last),
    .out_position_count     (out_position_count),
    .out_velocity_count     (out_velocity_count),
    .out_digital_inputs     (out_digital_inputs),
    .out_status_word        (out_status_word),
    .out_current_bits       (out_current_bits)
  );

endmodule

// ===== rtl/svcd_front.sv =====
// Front end: ID registers, frame matching, latched drive values, work entry build.
module svcd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [svcd_pkg::ID_W-1:0]   cfg_wdata,
  input  logic                        in_push,
  input  logic [svcd_pkg::ID_W-1:0]   in_frame_id,
  input  logic [svcd_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic                        q_full,
  output logic                        in_full,
  output logic                        q_push,
  output svcd_pkg::entry_t            q_entry
);
  import svcd_pkg::*;

  logic [ID_W-1:0] sample_id_r, reply_id_r;
  latch_t          lat_r, lat_nxt;
  logic            accept, is_reply, is_sample;
  logic [15:0]     cmd;
  logic [31:0]     word;
  logic [31:0]     cls;
  entry_t          ent;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign cmd     = in_payload[15:0];
  assign word    = in_payload[63:32];
  assign cls     = word & SR_CLASS_MASK;
  assign is_reply  = (in_frame_id == reply_id_r);
  assign is_sample = (in_frame_id == sample_id_r);

  always_comb begin
    lat_nxt      = lat_r;
    ent          = '0;
    ent.sr_code  = EV_OK;
    ent.sr_ask   = 1'b0;
    if (is_reply) begin
      unique case (cmd)
        CMD_SR: begin
          lat_nxt.status = word;
          ent.pend[SLOT_STATUS] = 1'b1;
          if (word[6]) begin
            ent.sr_ask = 1'b1;
          end else if (word[0]) begin
            priority if (cls == SR_CLASS_HEAT)  ent.sr_code = EV_OVERHEAT;
            else if (cls == SR_CLASS_SHORT) ent.sr_code = EV_SHORT;
            else if (cls == SR_CLASS_OVERV) ent.sr_code = EV_OVERVOLT;
            else if (cls == SR_CLASS_UNDRV) ent.sr_code = EV_UNDERVOLT;
            else ent.sr_ask = 1'b1;
          end else begin
            ent.sr_code = word[4] ? EV_OK : EV_MOTOR_OFF;
          end
        end
        CMD_MF: begin
          for (int i = 0; i < NUM_FAILS; i++) begin
            ent.pend[i+1] = word[FAIL_BITS[i]];
          end
        end
        CMD_HM: ent.pend[SLOT_HOMING] = (word[7:0] == 8'h00);
        CMD_IQ: lat_nxt.current = word;
        CMD_IP: lat_nxt.din = DIN_W'(word & DIN_MASK);
        default: ;
      endcase
    end
    if (is_sample) begin
      lat_nxt.position = in_payload[31:0];
      lat_nxt.velocity = word;
      ent.pend[SLOT_SAMPLE] = 1'b1;
    end
    ent.snap = lat_nxt;
  end

  assign q_push  = accept && (ent.pend != '0);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_id_r <= '0;
      reply_id_r  <= '0;
      lat_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SAMPLE_ID) sample_id_r <= cfg_wdata;
        if (cfg_index == CFG_REPLY_ID)  reply_id_r  <= cfg_wdata;
      end
      if (accept) lat_r <= lat_nxt;
    end
  end

endmodule

// ===== rtl/svcd_fifo.sv =====
// Small register queue between front and back ends.
module svcd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  `include "servo_drive_can_reply_decoder_macros.svh"

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  `SVCD_NEVER(a_fifo_overfill, count_r > CW'(DEPTH), "queue count beyond depth")
  `SVCD_NEVER(a_fifo_pop_empty, pop && empty, "back end popped an empty queue")
  `SVCD_NEVER(a_fifo_push_full, push && full, "front end pushed a full queue")

endmodule

// ===== rtl/svcd_back.sv =====
// Back end: expands a frame to results, one per cycle unless stalled.
module svcd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  svcd_pkg::entry_t             q_entry,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [svcd_pkg::CODE_W-1:0]  out_event_code,
  output logic                         out_ask_failure_detail,
  output logic                         out_last,
  output logic signed [31:0]           out_position_count,
  output logic signed [31:0]           out_velocity_count,
  output logic [svcd_pkg::DIN_W-1:0]   out_digital_inputs,
  output logic [31:0]                  out_status_word,
  output logic [31:0]                  out_current_bits
);
  import svcd_pkg::*;
  `include "servo_drive_can_reply_decoder_macros.svh"

  entry_t               cur_r;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [NUM_SLOTS-1:0] pend_r, pend_nxt, rest;
  logic                 out_valid_r;
  logic [CODE_W-1:0]    code_r;
  logic                 ask_r, last_r;
  latch_t               snap_r;
  logic [SLOT_W-1:0]    sel;
  logic                 adv, load;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) sel = SLOT_W'(i);
    end
  end

  assign rest  = pend_r & ~(NUM_SLOTS'(1) << sel);
  assign adv   = cur_valid_r && (!out_valid_r || out_pop);
  assign load  = !q_empty && (!cur_valid_r || (adv && rest == '0));
  assign q_pop = load;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    pend_nxt      = pend_r;
    if (adv) begin
      pend_nxt      = rest;
      cur_valid_nxt = (rest != '0);
    end
    if (load) begin
      pend_nxt      = q_entry.pend;
      cur_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (adv)          out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (load) cur_r <= q_entry;
    if (adv) begin
      code_r <= slot_code(sel, cur_r.sr_code);
      ask_r  <= (sel == SLOT_STATUS) && cur_r.sr_ask;
      last_r <= (rest == '0);
      snap_r <= cur_r.snap;
    end
  end

  assign out_empty              = !out_valid_r;
  assign out_event_code         = code_r;
  assign out_ask_failure_detail = ask_r;
  assign out_last               = last_r;
  assign out_position_count     = snap_r.position;
  assign out_velocity_count     = snap_r.velocity;
  assign out_digital_inputs     = snap_r.din;
  assign out_status_word        = snap_r.status;
  assign out_current_bits       = snap_r.current;

  `SVCD_NEVER(a_back_idle_pend, cur_valid_r && pend_r == '0, "active frame with no results")
  `SVCD_NEVER(a_back_ask_code, out_valid_r && ask_r && code_r != EV_OK, "ask with nonzero code")
  `SVCD_NEVER(a_back_code_range, out_valid_r && code_r > EV_DISARMED, "event code out of range")

endmodule

// ===== verif/svcd_event_checker.sv =====
// Checker for the servo drive CAN reply decoder: predicts event words and compares them.
module svcd_event_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [svcd_pkg::ID_W-1:0]      cfg_wdata,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic [svcd_pkg::ID_W-1:0]      in_frame_id,
  input  logic [svcd_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic                           out_pop,
  input  logic                           out_empty,
  input  logic [svcd_pkg::CODE_W-1:0]    out_event_code,
  input  logic                           out_ask_failure_detail,
  input  logic                           out_last,
  input  logic signed [31:0]             out_position_count,
  input  logic signed [31:0]             out_velocity_count,
  input  logic [svcd_pkg::DIN_W-1:0]     out_digital_inputs,
  input  logic [31:0]                    out_status_word,
  input  logic [31:0]                    out_current_bits,
  output int unsigned                    mismatches,
  output int unsigned                    words_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import svcd_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              ask;
    logic              last;
    logic [31:0]       position;
    logic [31:0]       velocity;
    logic [DIN_W-1:0]  din;
    logic [31:0]       status;
    logic [31:0]       current;
  } drive_word_t;

  logic [ID_W-1:0]  sample_id, reply_id;
  logic [31:0]      status_q, current_q, position_q, velocity_q;
  logic [DIN_W-1:0] din_q;
  drive_word_t      due_words[$];
  int unsigned      bad_count;

  // Decode one accepted frame and queue the event words it causes.
  task automatic decode_frame(input logic [ID_W-1:0] id, input logic [PAYLOAD_W-1:0] pl);
    logic [31:0]       word;
    logic [CODE_W-1:0] codes [7];
    logic              asks [7];
    logic [CODE_W-1:0] code;
    logic              ask;
    drive_word_t       w;
    int                n;
    word = pl[63:32];
    n = 0;
    if (id == reply_id) begin
      case (pl[15:0])
        CMD_SR: begin
          status_q = word;
          code = EV_OK;
          ask = 1'b0;
          if (word[6]) begin
            ask = 1'b1;
          end else if (word[0]) begin
            case (word & SR_CLASS_MASK)
              SR_CLASS_HEAT:  code = EV_OVERHEAT;
              SR_CLASS_SHORT: code = EV_SHORT;
              SR_CLASS_OVERV: code = EV_OVERVOLT;
              SR_CLASS_UNDRV: code = EV_UNDERVOLT;
              default:        ask = 1'b1;
            endcase
          end else if (!word[4]) begin
            code = EV_MOTOR_OFF;
          end
          codes[n] = code;
          asks[n] = ask;
          n++;
        end
        CMD_MF: begin
          for (int k = 0; k < NUM_FAILS; k++) begin
            if (word[FAIL_BITS[k]]) begin
              codes[n] = CODE_W'(EV_FEEDBACK_LOSS + k);
              asks[n] = 1'b0;
              n++;
            end
          end
        end
        CMD_HM: begin
          if (word[7:0] == 8'd0) begin
            codes[n] = EV_DISARMED;
            asks[n] = 1'b0;
            n++;
          end
        end
        CMD_IQ: current_q = word;
        CMD_IP: din_q = word[DIN_W-1:0];
        default: ;
      endcase
    end
    if (id == sample_id) begin
      position_q = pl[31:0];
      velocity_q = word;
      codes[n] = EV_OK;
      asks[n] = 1'b0;
      n++;
    end
    // latched values are shown as they stand after the whole frame
    for (int k = 0; k < n; k++) begin
      w.code     = codes[k];
      w.ask      = asks[k];
      w.last     = (k == n - 1);
      w.position = position_q;
      w.velocity = velocity_q;
      w.din      = din_q;
      w.status   = status_q;
      w.current  = current_q;
      due_words  = {due_words, w};
    end
  endtask

  task automatic check_word();
    drive_word_t got, want;
    got.code     = out_event_code;
    got.ask      = out_ask_failure_detail;
    got.last     = out_last;
    got.position = out_position_count;
    got.velocity = out_velocity_count;
    got.din      = out_digital_inputs;
    got.status   = out_status_word;
    got.current  = out_current_bits;
    if (due_words.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("[%0t] unexpected word: code=%0d ask=%0b last=%0b", $realtime,
                 got.code, got.ask, got.last);
      return;
    end
    want = due_words.pop_front();
    if (got !== want) begin
      bad_count++;
      if (bad_count <= 10) begin
        $display("[%0t] mismatch  exp: code=%0d ask=%0b last=%0b pos=%0d vel=%0d din=%h st=%h cur=%h",
                 $realtime, want.code, want.ask, want.last, $signed(want.position),
                 $signed(want.velocity), want.din, want.status, want.current);
        $display("            got: code=%0d ask=%0b last=%0b pos=%0d vel=%0d din=%h st=%h cur=%h",
                 got.code, got.ask, got.last, $signed(got.position),
                 $signed(got.velocity), got.din, got.status, got.current);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sample_id  = '0;
      reply_id   = '0;
      status_q   = '0;
      current_q  = '0;
      position_q = '0;
      velocity_q = '0;
      din_q      = '0;
      due_words.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SAMPLE_ID) sample_id = cfg_wdata;
        else reply_id = cfg_wdata;
      end
      if (out_pop && !out_empty) check_word();
      if (in_push && !in_full) decode_frame(in_frame_id, in_payload);
    end
    mismatches <= bad_count;
    words_due  <= due_words.size();
  end

endmodule

// ===== verif/tb_servo_drive_can_reply_decoder.sv =====
// Testbench top for the servo drive CAN reply decoder: stimulus, pacing and verdict.
module tb_servo_drive_can_reply_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import svcd_pkg::*;

  // Cycles with no word moved on either side before the run is declared hung.
  // Worst honest gap is the longest idle draw plus the drain pause.
  localparam int unsigned STALL_LIMIT  = 1000;
  // Pause after the last expected word: frames without results may still
  // be in flight, and a result trails its frame through queue and back end.
  localparam int unsigned DRAIN_CYCLES = 20;
  // Frames whose failure bits are all set give six words.
  localparam logic [31:0] ALL_FAIL_BITS = 32'h0022_018C;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic                  cfg_index;
  logic [ID_W-1:0]       cfg_wdata;
  logic                  in_push;
  logic                  in_full;
  logic [ID_W-1:0]       in_frame_id;
  logic [PAYLOAD_W-1:0]  in_payload;
  logic                  out_pop;
  logic                  out_empty;
  logic [CODE_W-1:0]     out_event_code;
  logic                  out_ask_failure_detail;
  logic                  out_last;
  logic signed [31:0]    out_position_count;
  logic signed [31:0]    out_velocity_count;
  logic [DIN_W-1:0]      out_digital_inputs;
  logic [31:0]           out_status_word;
  logic [31:0]           out_current_bits;

  int unsigned           mismatches;
  int unsigned           words_due;
  int unsigned           stall_cycles;
  logic [ID_W-1:0]       sample_id, reply_id;   // current register settings
  bit                    no_idle;               // phase with back-to-back traffic

  servo_drive_can_reply_decoder i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_frame_id            (in_frame_id),
    .in_payload             (in_payload),
    .out_pop                (out_pop),
    .out_empty              (out_empty),
    .out_event_code         (out_event_code),
    .out_ask_failure_detail (out_ask_failure_detail),
    .out_last               (out_last),
    .out_position_count     (out_position_count),
    .out_velocity_count     (out_velocity_count),
    .out_digital_inputs     (out_digital_inputs),
    .out_status_word        (out_status_word),
    .out_current_bits       (out_current_bits)
  );

  // Predicts every event word from what it sees on the ports.
  svcd_event_checker i_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_frame_id            (in_frame_id),
    .in_payload             (in_payload),
    .out_pop                (out_pop),
    .out_empty              (out_empty),
    .out_event_code         (out_event_code),
    .out_ask_failure_detail (out_ask_failure_detail),
    .out_last               (out_last),
    .out_position_count     (out_position_count),
    .out_velocity_count     (out_velocity_count),
    .out_digital_inputs     (out_digital_inputs),
    .out_status_word        (out_status_word),
    .out_current_bits       (out_current_bits),
    .mismatches             (mismatches),
    .words_due              (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle draw per word or frame, weighted toward short gaps so the queue
  // also fills; zero throughout a no-idle phase.
  function automatic int unsigned idle_draw();
    if (no_idle) return 0;
    case ($urandom_range(0, 3))
      0:       return 0;
      1, 2:    return $urandom_range(0, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // Watchdog: any cycle moving a word on either side restarts the count.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("** servo_drive_can_reply_decoder: FAILED **");
        $finish;
      end
    end
  end

  // Result side: after each popped word wait a random number of cycles,
  // then hold pop high until a word is taken.
  initial begin : pop_side
    int unsigned pop_gap;
    bit          took;
    out_pop = 1'b0;
    pop_gap = 0;
    forever begin
      @(posedge clk);
      took = out_pop && !out_empty;
      @(negedge clk);
      if (took) pop_gap = idle_draw();
      if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Push one frame; returns at the edge that took it with push still high,
  // so the next frame can follow without a bubble.
  task automatic send_frame(input logic [ID_W-1:0] id, input logic [PAYLOAD_W-1:0] pl);
    int unsigned gap;
    gap = idle_draw();
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push     <= 1'b1;
    in_frame_id <= id;
    in_payload  <= pl;
    do @(posedge clk); while (in_full);
  endtask

  // Reply frame: data word in bytes 4..7, filler in bytes 2..3, command letters.
  task automatic send_reply(input logic [15:0] cmd, input logic [31:0] word);
    send_frame(reply_id, {word, 16'($urandom), cmd});
  endtask

  // Stop pushing, let every expected word come out, then let the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic set_ids(input logic [ID_W-1:0] s_id, input logic [ID_W-1:0] r_id);
    sample_id = s_id;
    reply_id  = r_id;
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SAMPLE_ID;
    cfg_wdata <= s_id;
    @(negedge clk);
    cfg_index <= CFG_REPLY_ID;
    cfg_wdata <= r_id;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random frame: mostly well-formed replies and samples with random data,
  // some near-miss commands and foreign identifiers as noise.
  task automatic send_random();
    logic [ID_W-1:0] id;
    logic [15:0]     cmd;
    logic [31:0]     word;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) id = reply_id;
    else if (pick < 85) id = sample_id;
    else id = ID_W'($urandom);
    word = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        cmd = CMD_SR;
        // keep the fault-detail bit mostly clear so classification is reached
        if ($urandom_range(0, 2) != 0) word[6] = 1'b0;
        if ($urandom_range(0, 1) != 0) word[0] = 1'b1;
      end
      3, 4: begin
        cmd = CMD_MF;
        if ($urandom_range(0, 1) != 0) word = word & $urandom;
      end
      5: begin
        cmd = CMD_HM;
        if ($urandom_range(0, 1) != 0) word[7:0] = 8'd0;
      end
      6: cmd = CMD_IQ;
      7: cmd = CMD_IP;
      8: cmd = {CMD_SR[15:8], 8'($urandom)};   // one letter right
      default: cmd = 16'($urandom);
    endcase
    // sample frames carry raw counts in every byte
    if (id == sample_id && id != reply_id)
      send_frame(id, {32'($urandom), 32'($urandom)});
    else
      send_frame(id, {word, 16'($urandom), cmd});
  endtask

  // Extremes of each command, every status class, every latch.
  task automatic run_directed();
    send_reply(CMD_SR, 32'h0000_0040);          // detail bit: ok + ask
    send_reply(CMD_SR, 32'h0000_000D);          // overheat
    send_reply(CMD_SR, 32'h0000_000B);          // short
    send_reply(CMD_SR, 32'h0000_0005);          // overvoltage
    send_reply(CMD_SR, 32'h0000_0003);          // undervoltage
    send_reply(CMD_SR, 32'h0000_0001);          // fault, unknown class: ask
    send_reply(CMD_SR, 32'h0000_000F);          // fault, class 14: ask
    send_reply(CMD_SR, 32'h0000_0010);          // motor on: ok
    send_reply(CMD_SR, 32'h0000_0000);          // motor off
    send_reply(CMD_SR, 32'hFFFF_FFFF);          // detail bit wins over fault
    send_reply(CMD_MF, ALL_FAIL_BITS);          // six failure words
    send_reply(CMD_MF, 32'h0000_0000);          // nothing
    send_reply(CMD_MF, ~ALL_FAIL_BITS);         // only unrelated bits: nothing
    send_reply(CMD_MF, 32'h0020_0000);          // last failure bit only
    send_reply(CMD_HM, 32'hFFFF_FF00);          // byte 4 zero: disarmed
    send_reply(CMD_HM, 32'h0000_0001);          // still armed: nothing
    send_reply(CMD_IQ, 32'hFFFF_FFFF);
    send_reply(CMD_IP, 32'hFFFF_FFFF);          // upper bits dropped
    send_reply(16'h5858, 32'h1234_5678);        // unknown command
    send_frame(sample_id, 64'h7FFF_FFFF_8000_0000);
    send_frame(sample_id, 64'hFFFF_FFFF_FFFF_FFFF);
    send_reply(CMD_IQ, 32'h7F80_0000);
    send_reply(CMD_IP, 32'h0000_0000);
    send_frame(sample_id, 64'h0);
    send_frame(11'h7FF, 64'hFFFF_FFFF_FFFF_5253); // foreign id: ignored
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_random();
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_SAMPLE_ID;
    cfg_wdata   = '0;
    in_push     = 1'b0;
    in_frame_id = '0;
    in_payload  = '0;
    no_idle     = 1'b0;
    sample_id   = '0;
    reply_id    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // typical separate identifiers
    set_ids(11'h123, 11'h581);
    run_directed();
    run_random(40);
    settle();

    // extremes, back-to-back on both sides
    no_idle = 1'b1;
    set_ids(11'h7FF, 11'h000);
    run_random(40);
    settle();
    no_idle = 1'b0;

    set_ids(11'h000, 11'h7FF);
    run_random(35);
    settle();

    // shared identifier: reply words first, then the sample word
    set_ids(11'h2A5, 11'h2A5);
    send_reply(CMD_MF, ALL_FAIL_BITS);          // seven words from one frame
    send_reply(CMD_SR, 32'h0000_000D);
    send_reply(CMD_IQ, 32'h0000_0000);
    run_random(40);
    settle();

    set_ids(ID_W'($urandom), ID_W'($urandom));
    run_random(40);
    settle();

    if (mismatches == 0 && words_due == 0) begin
      $display("** servo_drive_can_reply_decoder: PASSED **");
    end else begin
      $display("** servo_drive_can_reply_decoder: FAILED **");
    end
    $finish;
  end

endmodule
